// ----- rtl/ihex_pkg.sv -----
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types, constants and the control store for the Intel HEX encoder.
// ----------------------------------------------------------------------------
package ihex_pkg;

   localparam int MAX_RECORD = 32;
   localparam int IDX_W      = $clog2(MAX_RECORD);
   localparam int FILL_W     = 6;
   localparam int STEP_W     = 6;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_RECORD_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FORMAT_MODE   = 1'b1;

   localparam logic [FILL_W-1:0] RECORD_LENGTH_RESET = 6'd16;

   // control store layout
   localparam logic [STEP_W-1:0] REC_ENTRY     = 6'd0;
   localparam logic [STEP_W-1:0] REC_DATA_STEP = 6'd9;
   localparam logic [STEP_W-1:0] EXT_ENTRY     = 6'd14;
   localparam logic [STEP_W-1:0] END0_ENTRY    = 6'd30;
   localparam logic [STEP_W-1:0] END1_ENTRY    = 6'd43;
   localparam logic [STEP_W-1:0] ROM_END       = 6'd56;
   localparam int EXT_LEN = 16;
   localparam int END_LEN = 13;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SUB   = 8'h1A;

   localparam logic [8*EXT_LEN-1:0] EXT_TEXT  = ":020000040000FA\n";
   localparam logic [8*END_LEN-1:0] END0_TEXT = {":0000000000\n", 8'h1A};
   localparam logic [8*END_LEN-1:0] END1_TEXT = {":00000001FF\n", 8'h1A};

   typedef enum logic [1:0] {
      OP_DATA  = 2'd0,
      OP_FLUSH = 2'd1,
      OP_EXT   = 2'd2,
      OP_END   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CH_LIT,
      CH_HI,
      CH_LO
   } char_sel_type;

   typedef enum logic [2:0] {
      B_COUNT,
      B_ADDR_HI,
      B_ADDR_LO,
      B_DATA,
      B_CKSUM
   } byte_sel_type;

   typedef enum logic [1:0] {
      J_NEXT,
      J_LOOP,
      J_TAIL,
      J_DONE
   } jump_type;

   typedef enum logic [1:0] {
      TAIL_NONE,
      TAIL_EXT,
      TAIL_END0,
      TAIL_END1
   } tail_type;

   typedef struct packed {
      char_sel_type      char_sel;
      byte_sel_type      byte_sel;
      logic [7:0]        lit;
      jump_type          jump;
      logic [STEP_W-1:0] target;
   } ucode_type;

   // program launch request from the datapath to the sequencer
   typedef struct packed {
      logic              go;
      logic [STEP_W-1:0] entry;
      tail_type          tail;
   } launch_type;

   // per-step control from the sequencer to the datapath
   typedef struct packed {
      logic         fire;
      char_sel_type char_sel;
      byte_sel_type byte_sel;
      logic [7:0]   lit;
      logic         idx_inc;
      logic         rec_close;
      logic         last;
   } ctl_type;

   // one character toward the pair packer
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } chr_type;

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      logic [7:0] c;
      if (v < 4'd10) begin
         c = 8'h30 + {4'h0, v};
      end else begin
         c = 8'h37 + {4'h0, v};
      end
      return c;
   endfunction

   // control store: one character per step
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] addr);
      ucode_type cw;
      int        k;
      cw = '0;
      k  = 0;
      case (addr)
         6'd0 : cw.lit = CHAR_COLON;
         6'd1 : begin cw.char_sel = CH_HI; cw.byte_sel = B_COUNT;   end
         6'd2 : begin cw.char_sel = CH_LO; cw.byte_sel = B_COUNT;   end
         6'd3 : begin cw.char_sel = CH_HI; cw.byte_sel = B_ADDR_HI; end
         6'd4 : begin cw.char_sel = CH_LO; cw.byte_sel = B_ADDR_HI; end
         6'd5 : begin cw.char_sel = CH_HI; cw.byte_sel = B_ADDR_LO; end
         6'd6 : begin cw.char_sel = CH_LO; cw.byte_sel = B_ADDR_LO; end
         6'd7 : cw.lit = CHAR_ZERO;
         6'd8 : cw.lit = CHAR_ZERO;
         6'd9 : begin cw.char_sel = CH_HI; cw.byte_sel = B_DATA;    end
         6'd10: begin
            cw.char_sel = CH_LO;
            cw.byte_sel = B_DATA;
            cw.jump     = J_LOOP;
            cw.target   = REC_DATA_STEP;
         end
         6'd11: begin cw.char_sel = CH_HI; cw.byte_sel = B_CKSUM;   end
         6'd12: begin cw.char_sel = CH_LO; cw.byte_sel = B_CKSUM;   end
         6'd13: begin cw.lit = CHAR_LF; cw.jump = J_TAIL;           end
         default: begin
            if (addr inside {[EXT_ENTRY : END0_ENTRY - 6'd1]}) begin
               k = int'(addr) - int'(EXT_ENTRY);
               cw.lit = EXT_TEXT[8*(EXT_LEN-1-k) +: 8];
               if (k == EXT_LEN - 1) cw.jump = J_DONE;
            end else if (addr inside {[END0_ENTRY : END1_ENTRY - 6'd1]}) begin
               k = int'(addr) - int'(END0_ENTRY);
               cw.lit = END0_TEXT[8*(END_LEN-1-k) +: 8];
               if (k == END_LEN - 1) cw.jump = J_DONE;
            end else if (addr inside {[END1_ENTRY : ROM_END - 6'd1]}) begin
               k = int'(addr) - int'(END1_ENTRY);
               cw.lit = END1_TEXT[8*(END_LEN-1-k) +: 8];
               if (k == END_LEN - 1) cw.jump = J_DONE;
            end else begin
               cw.jump = J_DONE;
            end
         end
      endcase
      return cw;
   endfunction

endpackage

// ----- rtl/ihex_seq.sv -----
// ----------------------------------------------------------------------------
// ihex_seq
// Step counter and control store lookup; one control word per character.
// ----------------------------------------------------------------------------
module ihex_seq (
   input  logic                clock,
   input  logic                reset,
   input  ihex_pkg::launch_type launch,
   input  logic                more,
   input  logic                chr_ready,
   output logic                busy,
   output ihex_pkg::ctl_type   ctl
);
   import ihex_pkg::*;

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   tail_type          tail_ff, tail_in;
   ucode_type         cw;
   logic              fire;

   assign cw   = ucode_rom(step_ff);
   assign fire = busy_ff && chr_ready;
   assign busy = busy_ff;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      tail_in = tail_ff;
      if (launch.go) begin
         busy_in = 1'b1;
         step_in = launch.entry;
         tail_in = launch.tail;
      end else if (fire) begin
         case (cw.jump)
            J_NEXT: step_in = STEP_W'(step_ff + 6'd1);
            J_LOOP: step_in = more ? cw.target : STEP_W'(step_ff + 6'd1);
            J_TAIL: begin
               case (tail_ff)
                  TAIL_EXT:  step_in = EXT_ENTRY;
                  TAIL_END0: step_in = END0_ENTRY;
                  TAIL_END1: step_in = END1_ENTRY;
                  default:   busy_in = 1'b0;
               endcase
            end
            default: busy_in = 1'b0;
         endcase
      end
   end

   always_comb begin
      ctl.fire      = fire;
      ctl.char_sel  = cw.char_sel;
      ctl.byte_sel  = cw.byte_sel;
      ctl.lit       = cw.lit;
      ctl.idx_inc   = (cw.jump == J_LOOP);
      ctl.rec_close = (cw.jump == J_TAIL);
      ctl.last      = (cw.jump == J_DONE) ||
                      ((cw.jump == J_TAIL) && (tail_ff == TAIL_NONE));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         tail_ff <= TAIL_NONE;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         tail_ff <= tail_in;
      end
   end

endmodule

// ----- rtl/ihex_dpath.sv -----
// ----------------------------------------------------------------------------
// ihex_dpath
// Record state, byte buffer, operation dispatch and character formation.
// ----------------------------------------------------------------------------
module ihex_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [1:0]                        operation,
   input  logic [7:0]                        data_byte,
   input  logic [15:0]                       address,
   input  logic                              csr_wr_en,
   input  logic [ihex_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ihex_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  ihex_pkg::ctl_type                 ctl,
   output ihex_pkg::launch_type              launch,
   output logic                              more,
   output ihex_pkg::chr_type                 chr
);
   import ihex_pkg::*;

   logic [7:0]        mem [MAX_RECORD];
   logic [7:0]        rd_data_ff;
   logic              wr_en;

   logic [FILL_W-1:0] fill_ff, fill_in, fill_inc, len_eff;
   logic [15:0]       load_ff, load_in;
   logic [15:0]       next_ff, next_in;
   logic [7:0]        sum_ff, sum_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [FILL_W-1:0] rec_len_ff;
   logic              fmt_ff;

   logic              close_en;
   logic [15:0]       close_addr;
   logic [7:0]        sel_byte, cksum;
   logic [3:0]        nib;
   op_type            op;

   assign op = op_type'(operation);

   always_comb begin
      if (rec_len_ff == '0) begin
         len_eff = FILL_W'(1);
      end else if (rec_len_ff > FILL_W'(MAX_RECORD)) begin
         len_eff = FILL_W'(MAX_RECORD);
      end else begin
         len_eff = rec_len_ff;
      end
   end

   assign fill_inc = (fill_ff < FILL_W'(MAX_RECORD)) ? FILL_W'(fill_ff + 6'd1) : fill_ff;
   assign more     = (FILL_W'(FILL_W'(idx_ff) + 6'd1) < fill_ff);
   assign cksum    = 8'(8'd0 - sum_ff - {2'b00, fill_ff});

   always_comb begin
      fill_in    = fill_ff;
      load_in    = load_ff;
      sum_in     = sum_ff;
      next_in    = next_ff;
      idx_in     = idx_ff;
      wr_en      = 1'b0;
      close_en   = 1'b0;
      close_addr = '0;
      launch     = '0;

      if (accept) begin
         case (op)
            OP_DATA: begin
               wr_en   = (fill_ff < FILL_W'(MAX_RECORD));
               fill_in = fill_inc;
               sum_in  = 8'(sum_ff + data_byte);
               if (fill_inc >= len_eff) begin
                  launch.go    = 1'b1;
                  launch.entry = REC_ENTRY;
                  launch.tail  = TAIL_NONE;
                  next_in      = 16'(address + 16'd1);
               end
            end
            OP_FLUSH: begin
               if (fill_ff != '0) begin
                  launch.go    = 1'b1;
                  launch.entry = REC_ENTRY;
                  launch.tail  = TAIL_NONE;
                  next_in      = address;
               end else begin
                  close_en   = 1'b1;
                  close_addr = address;
               end
            end
            OP_EXT: begin
               if (fmt_ff) begin
                  launch.go = 1'b1;
                  if (fill_ff != '0) begin
                     launch.entry = REC_ENTRY;
                     launch.tail  = TAIL_EXT;
                     next_in      = '0;
                  end else begin
                     launch.entry = EXT_ENTRY;
                     launch.tail  = TAIL_NONE;
                     close_en     = 1'b1;
                  end
               end
            end
            OP_END: begin
               launch.go = 1'b1;
               if (fill_ff != '0) begin
                  launch.entry = REC_ENTRY;
                  launch.tail  = fmt_ff ? TAIL_END1 : TAIL_END0;
                  next_in      = '0;
               end else begin
                  launch.entry = fmt_ff ? END1_ENTRY : END0_ENTRY;
                  launch.tail  = TAIL_NONE;
                  close_en     = 1'b1;
               end
            end
            default: ;
         endcase
      end

      if (ctl.fire && ctl.idx_inc) begin
         idx_in = IDX_W'(idx_ff + 1'b1);
      end
      if (ctl.fire && ctl.rec_close) begin
         close_en   = 1'b1;
         close_addr = next_ff;
      end

      // close the record: clear the buffer and load the next address
      if (close_en) begin
         fill_in = '0;
         load_in = close_addr;
         sum_in  = 8'(close_addr[15:8] + close_addr[7:0]);
         idx_in  = '0;
      end
   end

   always_comb begin
      case (ctl.byte_sel)
         B_COUNT:   sel_byte = {2'b00, fill_ff};
         B_ADDR_HI: sel_byte = load_ff[15:8];
         B_ADDR_LO: sel_byte = load_ff[7:0];
         B_DATA:    sel_byte = rd_data_ff;
         B_CKSUM:   sel_byte = cksum;
         default:   sel_byte = '0;
      endcase
      nib = (ctl.char_sel == CH_HI) ? sel_byte[7:4] : sel_byte[3:0];
      chr.valid = ctl.fire;
      chr.last  = ctl.last;
      chr.data  = (ctl.char_sel == CH_LIT) ? ctl.lit : hex_char(nib);
   end

   // byte buffer: read port follows the index the next step will use
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[fill_ff[IDX_W-1:0]] <= data_byte;
      end
      rd_data_ff <= mem[idx_in];
   end

   always_ff @(posedge clock) begin
      next_ff <= next_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         load_ff    <= '0;
         sum_ff     <= '0;
         idx_ff     <= '0;
         rec_len_ff <= RECORD_LENGTH_RESET;
         fmt_ff     <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         load_ff <= load_in;
         sum_ff  <= sum_in;
         idx_ff  <= idx_in;
         if (csr_wr_en && csr_index == REG_RECORD_LENGTH) begin
            rec_len_ff <= csr_wdata;
         end
         if (csr_wr_en && csr_index == REG_FORMAT_MODE) begin
            fmt_ff <= csr_wdata[0];
         end
      end
   end

endmodule

// ----- rtl/ihex_pack.sv -----
// ----------------------------------------------------------------------------
// ihex_pack
// Packs the character stream into pairs and holds the result register.
// ----------------------------------------------------------------------------
module ihex_pack (
   input  logic              clock,
   input  logic              reset,
   input  ihex_pkg::chr_type chr,
   output logic              chr_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_first_char,
   output logic [7:0]        rsp_second_char,
   output logic              rsp_pair_valid,
   output logic              rsp_last
);
   import ihex_pkg::*;

   logic       hold_valid_ff, hold_valid_in;
   logic [7:0] hold_ff, hold_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] second_ff, second_in;
   logic       pair_ff, pair_in;
   logic       last_ff, last_in;

   assign chr_ready = !out_valid_ff || rsp_ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      first_in      = first_ff;
      second_in     = second_ff;
      pair_in       = pair_ff;
      last_in       = last_ff;
      if (chr.valid) begin
         if (hold_valid_ff) begin
            first_in      = hold_ff;
            second_in     = chr.data;
            pair_in       = 1'b1;
            last_in       = chr.last;
            out_valid_in  = 1'b1;
            hold_valid_in = 1'b0;
         end else if (chr.last) begin
            // odd stream: send the final character alone
            first_in     = chr.data;
            second_in    = '0;
            pair_in      = 1'b0;
            last_in      = 1'b1;
            out_valid_in = 1'b1;
         end else begin
            hold_in       = chr.data;
            hold_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      hold_ff   <= hold_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      pair_ff   <= pair_in;
      last_ff   <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_first_char  = first_ff;
   assign rsp_second_char = second_ff;
   assign rsp_pair_valid  = pair_ff;
   assign rsp_last        = last_ff;

endmodule

// ----- rtl/intel_hex_record_encoder.sv -----
// ----------------------------------------------------------------------------
// intel_hex_record_encoder
// Frames object-code bytes into Intel HEX records, two ASCII chars per item.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  req       in         req_valid/req_ready    operation, data_byte, address
//  rsp       out        rsp_valid/rsp_ready    first/second char, pair_valid, last
//  csr       in         csr_wr_en              csr_index, csr_wdata
//
//  An input item is accepted on req_valid and req_ready, then the characters
//  it produces are emitted in order: a record of n bytes is 12 + 2n characters, the end text
//  13 and the extended-address text 16; the pair packer completes a
//  result every two. Reset is synchronous and restores registers and
//  record state. A stall on rsp freezes the step counter; req_ready stays
//  low until the last character of the current item has entered the packer.
//
module intel_hex_record_encoder (
   input  logic                              clock,
   input  logic                              reset,
   // input items
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_operation,
   input  logic [7:0]                        req_data_byte,
   input  logic [15:0]                       req_address,
   // result items
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_first_char,
   output logic [7:0]                        rsp_second_char,
   output logic                              rsp_pair_valid,
   output logic                              rsp_last,
   // configuration writes
   input  logic                              csr_wr_en,
   input  logic [ihex_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ihex_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ihex_pkg::*;

   launch_type launch;
   ctl_type    ctl;
   chr_type    chr;
   logic       busy;
   logic       more;
   logic       chr_ready;
   logic       accept;

   // take a new item only while the sequencer is idle
   assign req_ready = !busy;
   assign accept    = req_valid && req_ready;

   // step counter and control store
   ihex_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .launch    (launch),
      .more      (more),
      .chr_ready (chr_ready),
      .busy      (busy),
      .ctl       (ctl)
   );

   // record state, byte buffer and character formation
   ihex_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .operation (req_operation),
      .data_byte (req_data_byte),
      .address   (req_address),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ctl       (ctl),
      .launch    (launch),
      .more      (more),
      .chr       (chr)
   );

   // pair the characters and hold the result until taken
   ihex_pack u_pack (
      .clock           (clock),
      .reset           (reset),
      .chr             (chr),
      .chr_ready       (chr_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_first_char  (rsp_first_char),
      .rsp_second_char (rsp_second_char),
      .rsp_pair_valid  (rsp_pair_valid),
      .rsp_last        (rsp_last)
   );

endmodule
